// ----- design/drq_pkg.sv -----
package drq_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TIME_W   = 64;
  localparam int ID_W     = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_DELETE  = 2'd2
  } cmd_e;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   ident;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;        // latch the input beat, clear the scan position
    logic enq_write;   // append the latched entry
    logic rd_en;       // read the slot under the scan and the last slot
    logic drop;        // move the last entry into the scanned slot
    logic pos_inc;     // advance the scan
    logic pend_load;   // hold the released id until its last flag is known
    logic pend_clear;
    logic out_load;
    logic out_reject;
    logic out_last;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0]       cmd;
    logic             full;
    logic             scan_end;
    logic             hit;
    logic             pend_valid;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

// ----- design/drq_datapath.sv -----
module drq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  cmd,
  input  logic [drq_pkg::TIME_W-1:0]  time_value,
  input  logic [drq_pkg::ID_W-1:0]    entity_id,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        kind,
  output logic [drq_pkg::ID_W-1:0]    released_id,
  output logic                        last,
  input  drq_pkg::dp_cmd_t            c,
  output drq_pkg::dp_status_t         st
);

  drq_pkg::entry_t mem [drq_pkg::CAPACITY];

  logic [1:0]                 cmd_q;
  logic [drq_pkg::TIME_W-1:0] time_q;
  logic [drq_pkg::ID_W-1:0]   id_q;
  logic [drq_pkg::CNT_W-1:0]  count;
  logic [drq_pkg::CNT_W-1:0]  pos;
  logic [drq_pkg::CNT_W-1:0]  tail;
  drq_pkg::entry_t            rd_cur;
  drq_pkg::entry_t            rd_tail;
  logic                       pend_valid;
  logic [drq_pkg::ID_W-1:0]   pend_id;
  logic                       wr_en;
  logic [drq_pkg::IDX_W-1:0]  wr_addr;
  drq_pkg::entry_t            wr_data;

  assign tail = count - drq_pkg::CNT_W'(1);

  always_comb begin
    wr_en   = c.enq_write || c.drop;
    wr_addr = c.drop ? pos[drq_pkg::IDX_W-1:0] : count[drq_pkg::IDX_W-1:0];
    wr_data = c.drop ? rd_tail : drq_pkg::entry_t'{deadline: time_q, ident: id_q};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (c.rd_en) begin
      rd_cur  <= mem[pos[drq_pkg::IDX_W-1:0]];
      rd_tail <= mem[tail[drq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (c.take) begin
      cmd_q  <= cmd;
      time_q <= time_value;
      id_q   <= entity_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else begin
      if (c.take) begin
        pos <= '0;
      end else if (c.pos_inc) begin
        pos <= pos + drq_pkg::CNT_W'(1);
      end
      if (c.enq_write) begin
        count <= count + drq_pkg::CNT_W'(1);
      end else if (c.drop) begin
        count <= tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (c.pend_load) begin
      pend_valid <= 1'b1;
    end else if (c.pend_clear) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.pend_load) begin
      pend_id <= rd_cur.ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.out_load) begin
      kind        <= c.out_reject ? drq_pkg::KIND_REJECT : drq_pkg::KIND_RELEASE;
      released_id <= c.out_reject ? id_q : pend_id;
      last        <= c.out_last;
    end
  end

  always_comb begin
    st.cmd        = cmd_q;
    st.full       = (count >= drq_pkg::CNT_W'(drq_pkg::CAPACITY));
    st.scan_end   = (pos >= count);
    st.hit        = (cmd_q == drq_pkg::CMD_TICK) ? (rd_cur.deadline <= time_q)
                                                 : (rd_cur.ident == id_q);
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || out_ready;
    st.count      = count;
  end

endmodule

// ----- design/drq_ctrl.sv -----
module drq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  drq_pkg::dp_status_t st,
  output drq_pkg::dp_cmd_t    c
);

  drq_pkg::state_t state;
  drq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    c          = '0;
    in_ready   = 1'b0;
    unique case (state)
      drq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          c.take     = 1'b1;
          state_next = drq_pkg::ST_START;
        end
      end
      drq_pkg::ST_START: begin
        priority if (st.cmd == drq_pkg::CMD_ENQUEUE) begin
          if (!st.full) begin
            c.enq_write = 1'b1;
            state_next  = drq_pkg::ST_IDLE;
          end else if (st.out_free) begin
            c.out_load   = 1'b1;
            c.out_reject = 1'b1;
            c.out_last   = 1'b1;
            state_next   = drq_pkg::ST_IDLE;
          end
        end else if (st.cmd == drq_pkg::CMD_TICK || st.cmd == drq_pkg::CMD_DELETE) begin
          state_next = drq_pkg::ST_READ;
        end else begin
          state_next = drq_pkg::ST_IDLE;
        end
      end
      drq_pkg::ST_READ: begin
        c.rd_en    = 1'b1;
        state_next = drq_pkg::ST_EVAL;
      end
      drq_pkg::ST_EVAL: begin
        // A released id waits in the holding register until the next
        // release or the end of the scan tells whether it is the last beat.
        priority if (st.scan_end) begin
          if (!st.pend_valid) begin
            state_next = drq_pkg::ST_IDLE;
          end else if (st.out_free) begin
            c.out_load   = 1'b1;
            c.out_last   = 1'b1;
            c.pend_clear = 1'b1;
            state_next   = drq_pkg::ST_IDLE;
          end
        end else if (st.hit) begin
          if (st.cmd != drq_pkg::CMD_TICK) begin
            c.drop     = 1'b1;
            state_next = drq_pkg::ST_READ;
          end else if (!st.pend_valid || st.out_free) begin
            c.out_load  = st.pend_valid;
            c.pend_load = 1'b1;
            c.drop      = 1'b1;
            state_next  = drq_pkg::ST_READ;
          end
        end else begin
          c.pos_inc  = 1'b1;
          state_next = drq_pkg::ST_READ;
        end
      end
      default: begin
        state_next = drq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/deadline_release_queue.sv -----
// Unordered timer table of drq_pkg::CAPACITY (deadline, id) entries held in a
// two-read-port slot memory. A new beat is accepted only once the last
// command is finished. A tick or delete walks the occupied slots from the
// first, each slot visit being one memory read and then one compare and
// update, and it may wait on out_ready. Removal moves the last entry into
// the freed slot, which is checked again. Each tick release is one output beat
// of kind 0, the final one flagged by last; a full table turns an enqueue
// into a single kind 1 beat. A delete and the unused command code give no
// beat.
module deadline_release_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [drq_pkg::TIME_W-1:0] time_value,
  input  logic [drq_pkg::ID_W-1:0]   entity_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       kind,
  output logic [drq_pkg::ID_W-1:0]   released_id,
  output logic                       last
);

  drq_pkg::dp_cmd_t    c;
  drq_pkg::dp_status_t st;

  drq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .c        (c)
  );

  drq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .time_value  (time_value),
    .entity_id   (entity_id),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kind        (kind),
    .released_id (released_id),
    .last        (last),
    .c           (c),
    .st          (st)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    st.count <= drq_pkg::CNT_W'(drq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    c.drop |-> (st.count != '0) && !st.scan_end)
    else $error("removal with no entry under the scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    c.out_load |-> st.out_free)
    else $error("result beat overwritten before it was taken");

endmodule
